@@ rtl/core/scbd_pkg.sv @@
// ----------------------------------------------------------------------------
// scbd_pkg
// Shared types and marker constants of the spill and chip block deframer.
// ----------------------------------------------------------------------------
package scbd_pkg;

  localparam int unsigned WIN = 6;

  localparam logic [15:0] W_HDR    = 16'hfffc;
  localparam logic [15:0] W_END    = 16'hffff;
  localparam logic [15:0] W_CSTART = 16'hfffd;
  localparam logic [15:0] W_CEND   = 16'hfffe;
  localparam logic [15:0] W_FFLOW  = 16'hff00;
  localparam logic [15:0] W_SP     = 16'h5053;
  localparam logic [15:0] W_IL     = 16'h4c49;
  localparam logic [15:0] W_BL     = 16'h2020;
  localparam logic [15:0] W_CH     = 16'h4843;
  localparam logic [15:0] W_IP     = 16'h5049;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_SPILL  = 2'd1,
    MODE_TRHI   = 2'd2,
    MODE_TRLO   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_MATCH   = 2'd0,
    ST_DISCARD = 2'd1,
    ST_CUT     = 2'd2
  } spill_status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // One result beat.
  typedef struct packed {
    logic          kind;
    logic [15:0]   payload;
    logic          chip_last;
    logic [1:0]    spill_status;
    logic [31:0]   acquisition;
    logic          chip_dropped;
  } rec_t;

  // All results caused by one input word (one or two beats).
  typedef struct packed {
    logic [1:0]    cnt;
    rec_t [1:0]    rec;
  } bundle_t;

  // Front to queue write request.
  typedef struct packed {
    logic          valid;
    bundle_t       bundle;
  } push_t;

endpackage

@@ rtl/core/spill_and_chip_block_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// spill_and_chip_block_deframer_unit
// Spill and chip block deframer for a 16-bit raw readout stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_word): one raw stream word per beat.
// Output channel (out_valid/out_ready/out_*): one result per beat, either a
// chip payload word (out_kind 0, out_chip_last on the chip id) or a spill
// end status (out_kind 1); out_last marks the final result of an input word.
// Each input word yields zero, one or two results.
// An accepted word's bundle is written into the queue, then popped into the
// head register that shows its results. Throughput: one word per cycle while
// the queue has room; the front classifies a whole word combinationally
// against a six-word lookahead window. The single output port moves one
// result per cycle while out_ready is high, so a word with two results takes
// two output beats. When the receiver stalls, results collect in a
// QUEUE_DEPTH-entry queue of per-word bundles; in_ready drops only while
// that queue is full. Reset (rst_n low, synchronous): return to header
// search, empty window, drop any queued results.
// ----------------------------------------------------------------------------
module spill_and_chip_block_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [15:0]  in_word,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_kind,
  output logic [15:0]  out_payload,
  output logic         out_chip_last,
  output logic [1:0]   out_spill_status,
  output logic [31:0]  out_acquisition,
  output logic         out_chip_dropped,
  output logic         out_last
);

  scbd_pkg::push_t   push;
  scbd_pkg::bundle_t head;
  logic              q_empty;
  logic              q_full;
  logic              pop;
  logic              take;

  // Hold off the source only when no room is left for another bundle.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Front: window, header hunt, chip block classification.
  scbd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .word  (in_word),
    .push  (push)
  );

  // Decouple classification from the output handshake.
  scbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back: serialize each bundle onto the output channel.
  scbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload      (out_payload),
    .out_chip_last    (out_chip_last),
    .out_spill_status (out_spill_status),
    .out_acquisition  (out_acquisition),
    .out_chip_dropped (out_chip_dropped),
    .out_last         (out_last)
  );

endmodule

@@ rtl/core/scbd_front.sv @@
// ----------------------------------------------------------------------------
// scbd_front
// Header hunt, lookahead window and chip block classification per word.
// ----------------------------------------------------------------------------
module scbd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [15:0]          word,
  output scbd_pkg::push_t      push
);

  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_PAYLOAD = 2'd1,
    CLS_CHIP_ID = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic        chip_open;
    logic [2:0]  skip;
  } cls_res_t;

  function automatic cls_res_t classify(
    input logic [15:0] x,
    input logic [15:0] la0,
    input logic [15:0] la1,
    input logic [15:0] la2,
    input logic [15:0] la3,
    input logic        ge3,
    input logic        ge4,
    input logic        open_in,
    input logic [2:0]  skip_in
  );
    cls_res_t r;
    r.cls       = CLS_NONE;
    r.chip_open = open_in;
    r.skip      = skip_in;
    if (skip_in != 3'd0) begin
      r.skip = skip_in - 3'd1;
    end else if (open_in) begin
      if (ge3 && x == scbd_pkg::W_CEND && la0 >= scbd_pkg::W_FFLOW &&
          la1 == scbd_pkg::W_BL && la2 == scbd_pkg::W_BL) begin
        r.chip_open = 1'b0;
        r.skip      = 3'd3;
      end else if (ge4 && la0 == scbd_pkg::W_CEND && la1 >= scbd_pkg::W_FFLOW &&
                   la2 == scbd_pkg::W_BL && la3 == scbd_pkg::W_BL) begin
        r.chip_open = 1'b0;
        r.skip      = 3'd4;
        r.cls       = CLS_CHIP_ID;
      end else begin
        r.cls = CLS_PAYLOAD;
      end
    end else if (ge4 && x == scbd_pkg::W_CSTART && la0 >= scbd_pkg::W_FFLOW &&
                 la1 == scbd_pkg::W_CH && la2 == scbd_pkg::W_IP &&
                 la3 == scbd_pkg::W_BL) begin
      r.chip_open = 1'b1;
      r.skip      = 3'd4;
    end
    return r;
  endfunction

  scbd_pkg::mode_t mode_r, mode_nxt;
  logic [15:0]     win_r   [scbd_pkg::WIN];
  logic [15:0]     win_nxt [scbd_pkg::WIN];
  logic [15:0]     win_shift [scbd_pkg::WIN];
  logic [15:0]     win_ins   [scbd_pkg::WIN];
  logic [15:0]     win_ext   [scbd_pkg::WIN + 4];
  logic [2:0]      fill_r, fill_nxt;
  logic [31:0]     acq_r, acq_nxt;
  logic [15:0]     trhi_r, trhi_nxt;
  logic            open_r, open_nxt;
  logic [2:0]      skip_r, skip_nxt;
  logic            win_full;
  logic            hdr_hit;
  cls_res_t        ev_res;
  scbd_pkg::bundle_t bundle;

  // End-of-spill flush over the window.
  cls_res_t        fl_res;
  logic            fl_open;
  logic [2:0]      fl_skip;
  logic [1:0]      fl_cnt;
  logic [15:0]     fl_pw [2];
  logic            fl_pl [2];
  logic            fl_id0;
  logic            fl_idge1;

  assign win_full = (fill_r == 3'(scbd_pkg::WIN));

  always_comb begin
    for (int i = 0; i < scbd_pkg::WIN; i++) begin
      win_shift[i] = (i < scbd_pkg::WIN - 1) ? win_r[(i + 1) % scbd_pkg::WIN] : word;
      win_ins[i]   = (3'(i) == fill_r) ? word : win_r[i];
    end
    for (int i = 0; i < scbd_pkg::WIN + 4; i++) begin
      win_ext[i] = (i < scbd_pkg::WIN) ? win_r[i % scbd_pkg::WIN] : 16'h0000;
    end
  end

  // Walk the pending words in order, keep the first two that would be emitted.
  always_comb begin
    fl_open  = open_r;
    fl_skip  = skip_r;
    fl_cnt   = 2'd0;
    fl_pw[0] = 16'h0000;
    fl_pw[1] = 16'h0000;
    fl_pl[0] = 1'b0;
    fl_pl[1] = 1'b0;
    fl_id0   = 1'b0;
    fl_idge1 = 1'b0;
    fl_res   = '0;
    for (int i = 0; i < scbd_pkg::WIN; i++) begin
      if (3'(i) < fill_r) begin
        fl_res = classify(win_ext[i], win_ext[i + 1], win_ext[i + 2], win_ext[i + 3],
                          win_ext[i + 4], (i + 4) <= int'(fill_r),
                          (i + 5) <= int'(fill_r), fl_open, fl_skip);
        fl_open = fl_res.chip_open;
        fl_skip = fl_res.skip;
        if (fl_res.cls != CLS_NONE) begin
          if (fl_cnt == 2'd0) begin
            fl_pw[0] = win_r[i];
            fl_pl[0] = (fl_res.cls == CLS_CHIP_ID);
            fl_id0   = (fl_res.cls == CLS_CHIP_ID);
          end else begin
            if (fl_cnt == 2'd1) begin
              fl_pw[1] = win_r[i];
              fl_pl[1] = (fl_res.cls == CLS_CHIP_ID);
            end
            if (fl_res.cls == CLS_CHIP_ID) begin
              fl_idge1 = 1'b1;
            end
          end
          if (fl_cnt != 2'd2) begin
            fl_cnt = fl_cnt + 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    fill_nxt = fill_r;
    acq_nxt  = acq_r;
    trhi_nxt = trhi_r;
    open_nxt = open_r;
    skip_nxt = skip_r;
    hdr_hit  = 1'b0;
    ev_res   = '0;
    bundle   = '0;
    for (int i = 0; i < scbd_pkg::WIN; i++) begin
      win_nxt[i] = win_r[i];
    end

    case (mode_r)
      scbd_pkg::MODE_SPILL: begin
        if (word == scbd_pkg::W_END) begin
          // Release words up to the last chip id, at most two.
          bundle.rec[0].kind        = scbd_pkg::KIND_PAYLOAD;
          bundle.rec[0].payload     = fl_pw[0];
          bundle.rec[0].chip_last   = fl_pl[0];
          bundle.rec[0].acquisition = acq_r;
          bundle.rec[1].kind        = scbd_pkg::KIND_PAYLOAD;
          bundle.rec[1].payload     = fl_pw[1];
          bundle.rec[1].chip_last   = fl_pl[1];
          bundle.rec[1].acquisition = acq_r;
          bundle.cnt = fl_idge1 ? 2'd2 : (fl_id0 ? 2'd1 : 2'd0);
          open_nxt = fl_open;
          skip_nxt = fl_skip;
          fill_nxt = 3'd0;
          mode_nxt = scbd_pkg::MODE_TRHI;
        end else begin
          for (int i = 0; i < scbd_pkg::WIN; i++) begin
            win_nxt[i] = win_full ? win_shift[i] : win_ins[i];
          end
          fill_nxt = win_full ? fill_r : fill_r + 3'd1;
          if (win_full) begin
            ev_res = classify(win_r[0], win_shift[0], win_shift[1], win_shift[2],
                              win_shift[3], 1'b1, 1'b1, open_r, skip_r);
            open_nxt = ev_res.chip_open;
            skip_nxt = ev_res.skip;
            if (ev_res.cls != CLS_NONE) begin
              bundle.rec[0].kind        = scbd_pkg::KIND_PAYLOAD;
              bundle.rec[0].payload     = win_r[0];
              bundle.rec[0].chip_last   = (ev_res.cls == CLS_CHIP_ID);
              bundle.rec[0].acquisition = acq_r;
              bundle.cnt = 2'd1;
            end
          end
          hdr_hit = (fill_nxt == 3'(scbd_pkg::WIN)) && win_nxt[0] == scbd_pkg::W_HDR &&
                    win_nxt[3] == scbd_pkg::W_SP && win_nxt[4] == scbd_pkg::W_IL &&
                    win_nxt[5] == scbd_pkg::W_BL;
          if (hdr_hit) begin
            bundle.rec[bundle.cnt[0]].kind         = scbd_pkg::KIND_STATUS;
            bundle.rec[bundle.cnt[0]].spill_status = scbd_pkg::ST_CUT;
            bundle.rec[bundle.cnt[0]].acquisition  = acq_r;
            bundle.rec[bundle.cnt[0]].chip_dropped = open_nxt;
            bundle.cnt = bundle.cnt + 2'd1;
            acq_nxt  = {win_nxt[1], win_nxt[2]};
            open_nxt = 1'b0;
            skip_nxt = 3'd0;
            fill_nxt = 3'd0;
          end
        end
      end
      scbd_pkg::MODE_TRHI: begin
        trhi_nxt = word;
        mode_nxt = scbd_pkg::MODE_TRLO;
      end
      scbd_pkg::MODE_TRLO: begin
        bundle.rec[0].kind         = scbd_pkg::KIND_STATUS;
        bundle.rec[0].spill_status = ({trhi_r, word} != acq_r) ? scbd_pkg::ST_DISCARD
                                                               : scbd_pkg::ST_MATCH;
        bundle.rec[0].acquisition  = acq_r;
        bundle.rec[0].chip_dropped = open_r;
        bundle.cnt = 2'd1;
        open_nxt = 1'b0;
        skip_nxt = 3'd0;
        fill_nxt = 3'd0;
        mode_nxt = scbd_pkg::MODE_SEARCH;
      end
      default: begin
        for (int i = 0; i < scbd_pkg::WIN; i++) begin
          win_nxt[i] = win_full ? win_shift[i] : win_ins[i];
        end
        fill_nxt = win_full ? fill_r : fill_r + 3'd1;
        hdr_hit = (fill_nxt == 3'(scbd_pkg::WIN)) && win_nxt[0] == scbd_pkg::W_HDR &&
                  win_nxt[3] == scbd_pkg::W_SP && win_nxt[4] == scbd_pkg::W_IL &&
                  win_nxt[5] == scbd_pkg::W_BL;
        if (hdr_hit) begin
          acq_nxt  = {win_nxt[1], win_nxt[2]};
          open_nxt = 1'b0;
          skip_nxt = 3'd0;
          fill_nxt = 3'd0;
          mode_nxt = scbd_pkg::MODE_SPILL;
        end
      end
    endcase
  end

  assign push.valid  = take && (bundle.cnt != 2'd0);
  assign push.bundle = bundle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= scbd_pkg::MODE_SEARCH;
      fill_r <= 3'd0;
      acq_r  <= 32'd0;
      open_r <= 1'b0;
      skip_r <= 3'd0;
    end else if (take) begin
      mode_r <= mode_nxt;
      fill_r <= fill_nxt;
      acq_r  <= acq_nxt;
      open_r <= open_nxt;
      skip_r <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      trhi_r <= trhi_nxt;
      for (int i = 0; i < scbd_pkg::WIN; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

@@ rtl/core/scbd_queue.sv @@
// ----------------------------------------------------------------------------
// scbd_queue
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module scbd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scbd_pkg::push_t      push,
  input  logic                 pop,
  output scbd_pkg::bundle_t    head,
  output logic                 empty,
  output logic                 full
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  scbd_pkg::bundle_t mem_r [DEPTH];
  scbd_pkg::bundle_t head_r;
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  // Entry taken by the most recent pop.
  assign head    = head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.bundle;
    end
    if (do_pop) begin
      head_r <= mem_r[rd_ptr_r];
    end
  end

endmodule

@@ rtl/core/scbd_back.sv @@
// ----------------------------------------------------------------------------
// scbd_back
// Output stage: unpack one bundle into one or two result beats.
// ----------------------------------------------------------------------------
module scbd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  scbd_pkg::bundle_t    head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [15:0]          out_payload,
  output logic                 out_chip_last,
  output logic [1:0]           out_spill_status,
  output logic [31:0]          out_acquisition,
  output logic                 out_chip_dropped,
  output logic                 out_last
);

  logic              cur_valid_r, cur_valid_nxt;
  logic              idx_r, idx_nxt;
  scbd_pkg::rec_t    rec;
  logic              is_final;
  logic              fin;
  logic              load;

  // The queue holds the popped bundle in head until the next pop.
  assign is_final = (({1'b0, idx_r} + 2'd1) == head.cnt);
  assign fin      = cur_valid_r && out_ready && is_final;
  assign load     = (!cur_valid_r || fin) && !q_empty;
  assign pop      = load;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 1'b0;
    end else if (fin) begin
      cur_valid_nxt = 1'b0;
      idx_nxt       = 1'b0;
    end else if (cur_valid_r && out_ready) begin
      idx_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign rec              = head.rec[idx_r];
  assign out_valid        = cur_valid_r;
  assign out_kind         = rec.kind;
  assign out_payload      = rec.payload;
  assign out_chip_last    = rec.chip_last;
  assign out_spill_status = rec.spill_status;
  assign out_acquisition  = rec.acquisition;
  assign out_chip_dropped = rec.chip_dropped;
  assign out_last         = is_final;

endmodule
